// File: src/lrukv_pkg.sv
`default_nettype none

package lrukv_pkg;

	localparam int DATA_BITS      = 32;
	localparam int CAP_BITS       = 5;
	localparam int CAP_RESET      = 16;
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	typedef struct packed {
		op_t                          opcode;
		logic signed [DATA_BITS-1:0] key;
		logic signed [DATA_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                         found;
		logic signed [DATA_BITS-1:0] read_value;
		logic                         evicted;
		logic signed [DATA_BITS-1:0] evicted_key;
	} rsp_t;

	// broadcast to every cell of the recency chain
	typedef struct packed {
		logic apply;
		logic hit;
		logic evict;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: src/lrukv_cell.sv
`default_nettype none

module lrukv_cell import lrukv_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [KEY_BITS-1:0]   look_key,
	input  wire logic                  seen_in,
	output logic                       seen_out,
	output logic                       match,
	input  wire logic                  prev_valid,
	input  wire logic [KEY_BITS-1:0]   prev_key,
	input  wire logic [VALUE_BITS-1:0] prev_value,
	output logic                       valid,
	output logic [KEY_BITS-1:0]        key,
	output logic [VALUE_BITS-1:0]      value
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  load;

	assign match    = valid_q && (key_q == look_key);
	assign seen_out = seen_in | match;

	// hit: cells up to and including the hit take from the neighbour
	// miss: valid cells shift on; the first free one fills unless evicting
	assign load = ctl.apply &&
		(ctl.hit ? !seen_in : (valid_q || (!ctl.evict && prev_valid)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign value = value_q;

endmodule

`default_nettype wire

// File: src/lru_key_value_cache.sv
`default_nettype none

// channel | dir | handshake            | payload
// req     | in  | req_valid/req_stall  | req   (opcode, key, value)
// rsp     | out | rsp_valid/rsp_stall  | rsp   (found, read_value, evicted, evicted_key)
// cfg     | in  | cfg_valid/cfg_ready  | cfg_data (capacity)
//
// One item per cycle while rsp is not stalled. An accepted item is registered in the
// capture stage; it then goes through the compare along the chain of cells (ordered
// most to least recent) and shift, which loads the result register. A stalled rsp holds
// the result and the next item waits in the capture stage. Reset empties all cells; no sweep.
// cfg_ready is always high.

module lru_key_value_cache import lrukv_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire req_t                req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output rsp_t                     rsp,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CAP_BITS-1:0] cfg_data
);

	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW    = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

	logic [CAP_BITS-1:0]   cap_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  valid_s1;
	op_t                   op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  go;
	logic                  hit;
	logic                  evict;
	logic [CW-1:0]         eff_cap;
	cell_ctl_t             ctl;
	logic [VALUE_BITS-1:0] hit_value;
	logic [KEY_BITS-1:0]   victim_key;

	logic                  seen [ENTRIES+1];
	logic                  c_valid [ENTRIES+1];
	logic [KEY_BITS-1:0]   c_key [ENTRIES+1];
	logic [VALUE_BITS-1:0] c_value [ENTRIES+1];
	logic                  c_match [ENTRIES];

	assign cfg_ready = 1'b1;
	assign go        = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !go;

	// chain head: the item being written back as most recent
	assign seen[0]    = 1'b0;
	assign c_valid[0] = 1'b1;
	assign c_key[0]   = key_s1;
	assign c_value[0] = (op_s1 == OP_SET) ? value_s1 : hit_value;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lrukv_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.look_key   (key_s1),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.match      (c_match[i]),
			.prev_valid (c_valid[i]),
			.prev_key   (c_key[i]),
			.prev_value (c_value[i]),
			.valid      (c_valid[i+1]),
			.key        (c_key[i+1]),
			.value      (c_value[i+1])
		);
	end

	assign hit = seen[ENTRIES];

	always_comb begin
		hit_value  = '0;
		victim_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (c_match[i]) begin
				hit_value = hit_value | c_value[i+1];
			end
			// least recent: last valid cell of the prefix
			if (c_valid[i+1] && (OCC_W'(i + 1) == occ_q)) begin
				victim_key = victim_key | c_key[i+1];
			end
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign evict     = !hit && (CW'(occ_q) >= eff_cap);
	assign ctl.apply = go && (hit || op_s1 == OP_SET);
	assign ctl.hit   = hit;
	assign ctl.evict = evict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_BITS'(CAP_RESET);
			occ_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (go && op_s1 == OP_SET && !hit && !evict) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1    <= req.opcode;
			key_s1   <= KEY_BITS'($unsigned(req.key));
			value_s1 <= VALUE_BITS'($unsigned(req.value));
		end
		if (go) begin
			rsp_q.found   <= hit;
			rsp_q.evicted <= (op_s1 == OP_SET) && evict;
			if (op_s1 == OP_SET) begin
				rsp_q.read_value <= '0;
			end else if (hit) begin
				rsp_q.read_value <= DATA_BITS'(hit_value);
			end else begin
				rsp_q.read_value <= '1;
			end
			if (op_s1 == OP_SET && evict) begin
				rsp_q.evicted_key <= DATA_BITS'(victim_key);
			end else begin
				rsp_q.evicted_key <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: tb/sv/lru_key_value_cache_tb.sv
`default_nettype none

module lru_key_value_cache_tb;
	import lrukv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_SIZE   = 24;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] cfg_data  = '0;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the cache contents
	logic [DATA_BITS-1:0] cache_keys     [ENTRIES_DEF];
	logic [DATA_BITS-1:0] cache_vals     [ENTRIES_DEF];
	logic                 cache_valid    [ENTRIES_DEF] = '{default: 1'b0};
	logic [3:0]           cache_rank     [ENTRIES_DEF] = '{default: 4'd0};
	logic [CAP_BITS-1:0]  cache_occupied = '0;
	logic [CAP_BITS-1:0]  model_capacity = CAP_BITS'(CAP_RESET);

	rsp_t                 expected_rsps[$];
	logic [DATA_BITS-1:0] key_pool [POOL_SIZE];

	int items_sent    = 0;
	int results_seen  = 0;
	int mismatches    = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	// make entry idx the most recent
	function automatic void promote_entry(input int idx);
		logic [3:0] old_rank;
		old_rank = cache_rank[idx];
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (cache_valid[i] && cache_rank[i] < old_rank)
				cache_rank[i]++;
		cache_rank[idx] = 4'd0;
	endfunction

	function automatic rsp_t lru_access(input req_t r);
		rsp_t                o;
		int                  hit;
		int                  victim;
		int                  slot;
		logic [CAP_BITS-1:0] limit;
		o      = '0;
		hit    = -1;
		victim = -1;
		slot   = -1;
		if (model_capacity == 0)
			limit = CAP_BITS'(1);
		else if (model_capacity > ENTRIES_DEF)
			limit = CAP_BITS'(ENTRIES_DEF);
		else
			limit = model_capacity;
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (hit < 0 && cache_valid[i] && cache_keys[i] == r.key)
				hit = i;
		if (r.opcode == OP_GET) begin
			if (hit >= 0) begin
				o.found      = 1'b1;
				o.read_value = cache_vals[hit];
				promote_entry(hit);
			end else begin
				o.read_value = '1;
			end
		end else if (hit >= 0) begin
			o.found         = 1'b1;
			cache_vals[hit] = r.value;
			promote_entry(hit);
		end else begin
			if (cache_occupied >= limit) begin
				for (int i = 0; i < ENTRIES_DEF; i++)
					if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
						victim = i;
				if (victim >= 0) begin
					o.evicted           = 1'b1;
					o.evicted_key       = cache_keys[victim];
					cache_valid[victim] = 1'b0;
					cache_occupied--;
					slot = victim;
				end
			end
			if (slot < 0)
				for (int i = 0; i < ENTRIES_DEF; i++)
					if (slot < 0 && !cache_valid[i])
						slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < ENTRIES_DEF; i++)
					if (cache_valid[i])
						cache_rank[i]++;
				cache_keys[slot]  = r.key;
				cache_vals[slot]  = r.value;
				cache_valid[slot] = 1'b1;
				cache_rank[slot]  = 4'd0;
				cache_occupied++;
			end
		end
		return o;
	endfunction

	always @(posedge clk) begin : scoreboard
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_capacity = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: found=%0d rd=%h ev=%0d evk=%h",
							rsp.found, rsp.read_value, rsp.evicted, rsp.evicted_key);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.found !== want.found || rsp.read_value !== want.read_value ||
						rsp.evicted !== want.evicted || rsp.evicted_key !== want.evicted_key) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp found=%0d rd=%h ev=%0d evk=%h, ",
								"got found=%0d rd=%h ev=%0d evk=%h"},
								want.found, want.read_value, want.evicted, want.evicted_key,
								rsp.found, rsp.read_value, rsp.evicted, rsp.evicted_key);
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsps.push_back(lru_access(req));
		end
	end

	task automatic send_req(input op_t op, input logic [DATA_BITS-1:0] key,
		input logic [DATA_BITS-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		req.opcode   <= op;
		req.key      <= key;
		req.value    <= value;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drain();
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
		req_valid <= 1'b0;
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_basic_ops();
		send_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
		send_req(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
		send_req(OP_SET, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_SET, 32'hffff_ffff, 32'hffff_ffff);
		send_req(OP_GET, 32'h8000_0000, 32'hffff_ffff);
		send_req(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
		send_req(OP_SET, 32'h0000_0000, 32'h1234_5678);
		send_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_GET, 32'h0000_0005, 32'h0000_0000);
		send_req(OP_GET, 32'hffff_ffff, 32'h0000_0000);
	endtask

	// occupancy stays above the new capacity, each set miss evicts one
	task automatic test_capacity_shrink();
		write_capacity(5'd2);
		send_req(OP_SET, 32'd100, 32'hdead_beef);
		send_req(OP_SET, 32'd101, 32'h0bad_f00d);
		send_req(OP_GET, 32'd100, 32'h0000_0000);
		send_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
	endtask

	task automatic test_capacity_zero();
		write_capacity(5'd0);
		send_req(OP_SET, 32'd200, 32'h5555_aaaa);
		send_req(OP_GET, 32'd200, 32'h0000_0000);
	endtask

	task automatic test_capacity_saturate();
		write_capacity(5'd31);
		send_req(OP_SET, 32'd300, 32'haaaa_5555);
		send_req(OP_SET, 32'd301, 32'h0000_0001);
		send_req(OP_GET, 32'd300, 32'h0000_0000);
	endtask

	task automatic test_random_traffic(input logic [CAP_BITS-1:0] cap, input int idle_pct,
		input int hold_pct, input int count);
		logic [DATA_BITS-1:0] key;
		write_capacity(cap);
		send_idle_pct = idle_pct;
		stall_pct     = hold_pct;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0)
				key = $urandom;
			else if ($urandom_range(1) == 0)
				key = key_pool[$urandom_range(3)];
			else
				key = key_pool[$urandom_range(POOL_SIZE-1)];
			send_req(op_t'($urandom_range(1)), key, $urandom);
		end
	endtask

	initial begin
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_shrink();
		test_capacity_zero();
		test_capacity_saturate();

		test_random_traffic(5'd16, 0, 0, 170);
		test_random_traffic(5'd31, 61, 0, 170);
		test_random_traffic(5'd1, 0, 61, 170);
		test_random_traffic(5'd0, 33, 33, 170);
		test_random_traffic(5'd8, 0, 0, 170);
		test_random_traffic(5'd17, 61, 0, 170);
		test_random_traffic(5'd2, 0, 61, 170);
		test_random_traffic(CAP_BITS'($urandom_range(31)), 33, 33, 170);

		req_valid <= 1'b0;
		wait_drain();
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
src/lrukv_pkg.sv
src/lrukv_cell.sv
src/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
